// ----- sv/mnb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnb_pkg
// Types and constants shared by the meter needle ballistics block and its
// checker.
// ----------------------------------------------------------------------------
package mnb_pkg;

   // datapath sizing of the shared add/subtract unit
   localparam int ACC_W        = 66;   // accumulator, holds (k*err - c*vel)*h
   localparam int MUL_W        = 24;   // widest multiplier operand (stiffness)
   localparam int REM_W        = 8;    // remainder after the reciprocal loop
   localparam int DIV_CNT_W    = 4;    // counts reciprocal iterations
   localparam int DIV_ITERS    = 8;    // q = (y + 3q) >> 7 updates after q0
   localparam int DIV_K        = 125;  // odd factor of both divisors
   localparam int SHIFT_SPRING = 11;   // 256000 = 125 << 11
   localparam int SHIFT_POS    = 3;    // 1000 = 125 << 3

   // configuration register indexes
   localparam logic [2:0] CSR_DBM_AT_S9        = 3'd0;
   localparam logic [2:0] CSR_ANGLE_AT_S9      = 3'd1;
   localparam logic [2:0] CSR_SLOPE_BELOW_S9   = 3'd2;
   localparam logic [2:0] CSR_SLOPE_ABOVE_S9   = 3'd3;
   localparam logic [2:0] CSR_FULL_SCALE_ANGLE = 3'd4;
   localparam logic [2:0] CSR_RELEASE_PER_MS   = 3'd5;
   localparam logic [2:0] CSR_SPRING_STIFFNESS = 3'd6;
   localparam logic [2:0] CSR_SPRING_DAMPING   = 3'd7;

   typedef struct packed {
      logic [15:0] elapsed_ms;
      logic        dbm_valid;
      logic [7:0]  dbm_code;
      logic [3:0]  s_units;
   } mnb_req_type;

   typedef struct packed {
      logic [15:0] needle_angle;
      logic [15:0] target_angle;
      logic        repaint;
   } mnb_rsp_type;

   typedef struct packed {
      logic signed [8:0] dbm_at_s9;
      logic [15:0]       angle_at_s9;
      logic [15:0]       slope_below_s9;
      logic [15:0]       slope_above_s9;
      logic [15:0]       full_scale_angle;
      logic [15:0]       release_per_ms;
      logic [23:0]       spring_stiffness;
      logic [19:0]       spring_damping;
   } mnb_cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_TARGET,
      ST_DECIDE,
      ST_DK_LOAD,
      ST_DK_MUL,
      ST_DR_LOAD,
      ST_DR_MUL,
      ST_DR_ADD,
      ST_SP_ERR,
      ST_SP_MK,
      ST_SP_MC,
      ST_SP_MH,
      ST_SP_ABS,
      ST_DV_TRI,
      ST_DV_SUM,
      ST_DV_REM,
      ST_DV_FIX,
      ST_SP_SGN,
      ST_SP_UPD,
      ST_STOPS,
      ST_OUT
   } mnb_state_type;

endpackage

// ----- sv/meter_needle_ballistics.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_needle_ballistics
// Analog meter needle model: level to target angle, peak-hold drive with
// per-ms release decay, damped spring needle in substeps, repaint flag.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------
//  req_     | in        | valid / stall      | mnb_req_type (tick item)
//  rsp_     | out       | valid / stall      | mnb_rsp_type (needle state)
//  csr_     | in        | valid / ready      | index 3 bits, data 24 bits
//
//  One tick runs on a single shared 66-bit add/subtract unit: shift-add
//  multiplies (one multiplier bit a cycle) and divides by 256000 and 1000 as a
//  shift plus a divide by 125 (q = (y + 3q) >> 7 repeated, one remainder fix).
//  The release decay factor is computed only on release (target below the
//  drive); zero elapsed time skips the decay and the spring substeps.
//  Reset is synchronous and restores register defaults and zero needle state.
//  req_stall is high while a tick is in work; a finished result waits in the
//  output register under rsp_stall while the next tick is accepted.
// ----------------------------------------------------------------------------
module meter_needle_ballistics #(
   parameter int SUBSTEP_MS      = 5,
   parameter int MAX_DT_MS       = 100,
   parameter int MIN_MOVE_Q8     = 64,
   parameter int FRAME_MS        = 20,
   parameter int DBM_CODE_OFFSET = 200
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mnb_pkg::mnb_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mnb_pkg::mnb_rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_data
);
   import mnb_pkg::*;

   localparam int DT_W  = $clog2(MAX_DT_MS + 1);
   localparam int H_W   = $clog2(SUBSTEP_MS + 1);
   localparam int CNT_W = (DT_W > DIV_CNT_W) ? DT_W : DIV_CNT_W;

   mnb_state_type state_ff, state_in;
   mnb_cfg_type   cfg_ff;
   mnb_req_type   req_ff, req_in;
   mnb_rsp_type   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [15:0]        tgt_ff, tgt_in;
   logic [DT_W-1:0]    left_ff, left_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [16:0]        fac_ff, fac_in;
   logic [23:0]        drive_ff, drive_in;
   logic signed [31:0] pos_ff, pos_in;
   logic signed [31:0] vel_ff, vel_in;
   logic [15:0]        drawn_ff, drawn_in;
   logic [15:0]        msd_ff, msd_in;
   logic [ACC_W-1:0]   mcand_ff, mcand_in;
   logic [MUL_W-1:0]   mplier_ff, mplier_in;
   logic [ACC_W-1:0]   accum_ff, accum_in;
   logic [ACC_W-1:0]   quo_ff, quo_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               sign_ff, sign_in;
   logic               phase_ff, phase_in;

   // shared add/subtract unit
   logic [ACC_W-1:0] add_a, add_b, add_out;
   logic             add_sub;

   assign add_out = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_sub);

   function automatic logic signed [31:0] sat32(input logic [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (!v[ACC_W-1] && (|v[ACC_W-2:31]))
         r = 32'sh7FFF_FFFF;
      else if (v[ACC_W-1] && !(&v[ACC_W-2:31]))
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

   // handshakes
   logic req_xfer, slot_free, mul_done;

   assign req_xfer  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign mul_done  = (mplier_ff == '0);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // level to target angle
   logic [11:0]        lvl_diff;
   logic [3:0]         su_lo, su_hi;
   logic [15:0]        slope_sel;
   logic signed [28:0] tgt_prod;
   logic signed [29:0] tgt_sum;
   logic [15:0]        tgt_calc;

   always_comb begin
      su_lo = 4'd9 - req_ff.s_units;
      su_hi = req_ff.s_units - 4'd9;
      if (req_ff.dbm_valid)
         lvl_diff = {4'b0000, req_ff.dbm_code} - 12'(DBM_CODE_OFFSET)
                    - {{3{cfg_ff.dbm_at_s9[8]}}, cfg_ff.dbm_at_s9};
      else if (req_ff.s_units <= 4'd9)
         lvl_diff = 12'd0 - ({8'b0, su_lo} * 12'd6);
      else
         lvl_diff = {8'b0, su_hi} * 12'd10;
      slope_sel = (lvl_diff[11] || lvl_diff == 12'd0) ? cfg_ff.slope_below_s9
                                                       : cfg_ff.slope_above_s9;
      tgt_prod  = $signed(lvl_diff) * $signed({1'b0, slope_sel});
      tgt_sum   = $signed({14'b0, cfg_ff.angle_at_s9}) + 30'(tgt_prod);
      if (tgt_sum < 0)
         tgt_calc = 16'd0;
      else if (tgt_sum > $signed({14'b0, cfg_ff.full_scale_angle}))
         tgt_calc = cfg_ff.full_scale_angle;
      else
         tgt_calc = tgt_sum[15:0];
   end

   // tick timing
   logic [23:0]      tq, full_q16;
   logic [DT_W-1:0]  dt_sel;
   logic [H_W-1:0]   h_sel;
   logic             zero_tick;

   assign tq        = {tgt_ff, 8'b0};
   assign full_q16  = {cfg_ff.full_scale_angle, 8'b0};
   assign zero_tick = (req_ff.elapsed_ms == 16'd0);

   always_comb begin
      if (req_ff.elapsed_ms > 16'(MAX_DT_MS))
         dt_sel = DT_W'(MAX_DT_MS);
      else
         dt_sel = req_ff.elapsed_ms[DT_W-1:0];
      if (32'(left_ff) < SUBSTEP_MS)
         h_sel = H_W'(left_ff);
      else
         h_sel = H_W'(SUBSTEP_MS);
   end

   // needle readout and repaint decision
   logic [23:0] p_clamp;
   logic [24:0] p_round;
   logic [15:0] needle, move;
   logic [16:0] msd_sum;
   logic [15:0] msd_sat;
   logic        paint;

   always_comb begin
      if (pos_ff[31])
         p_clamp = 24'd0;
      else if (pos_ff > $signed({8'b0, full_q16}))
         p_clamp = full_q16;
      else
         p_clamp = pos_ff[23:0];
      p_round = {1'b0, p_clamp} + 25'd128;
      if (p_round[24:8] > {1'b0, cfg_ff.full_scale_angle})
         needle = cfg_ff.full_scale_angle;
      else
         needle = p_round[23:8];
      move    = (needle >= drawn_ff) ? needle - drawn_ff : drawn_ff - needle;
      msd_sum = {1'b0, msd_ff} + {1'b0, req_ff.elapsed_ms};
      msd_sat = msd_sum[16] ? 16'hFFFF : msd_sum[15:0];
      paint   = !zero_tick && (move >= 16'(MIN_MOVE_Q8)) && (msd_sat >= 16'(FRAME_MS));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_xfer) state_in = ST_TARGET;
         ST_TARGET:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (zero_tick)       state_in = ST_OUT;
            else if (tq >= drive_ff) state_in = ST_SP_ERR;
            else                 state_in = ST_DK_LOAD;
         end
         ST_DK_LOAD: state_in = ST_DK_MUL;
         ST_DK_MUL: begin
            if (mul_done) state_in = (cnt_ff == CNT_W'(1)) ? ST_DR_LOAD : ST_DK_LOAD;
         end
         ST_DR_LOAD: state_in = ST_DR_MUL;
         ST_DR_MUL:  if (mul_done) state_in = ST_DR_ADD;
         ST_DR_ADD:  state_in = ST_SP_ERR;
         ST_SP_ERR:  state_in = ST_SP_MK;
         ST_SP_MK:   if (mul_done) state_in = ST_SP_MC;
         ST_SP_MC:   if (mul_done) state_in = ST_SP_MH;
         ST_SP_MH:   if (mul_done) state_in = ST_SP_ABS;
         ST_SP_ABS:  state_in = ST_DV_TRI;
         ST_DV_TRI:  state_in = ST_DV_SUM;
         ST_DV_SUM:  state_in = (cnt_ff == '0) ? ST_DV_REM : ST_DV_TRI;
         ST_DV_REM:  state_in = ST_DV_FIX;
         ST_DV_FIX:  state_in = ST_SP_SGN;
         ST_SP_SGN:  state_in = ST_SP_UPD;
         ST_SP_UPD: begin
            if (!phase_ff)                      state_in = ST_SP_MH;
            else if (left_ff == DT_W'(h_sel))   state_in = ST_STOPS;
            else                                state_in = ST_SP_ERR;
         end
         ST_STOPS:   state_in = ST_OUT;
         ST_OUT:     if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   logic signed [31:0] upd_sat;
   logic [ACC_W-1:0]   div_y;

   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tgt_in       = tgt_ff;
      left_in      = left_ff;
      cnt_in       = cnt_ff;
      fac_in       = fac_ff;
      drive_in     = drive_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      drawn_in     = drawn_ff;
      msd_in       = msd_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      accum_in     = accum_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      sign_in      = sign_ff;
      phase_in     = phase_ff;
      add_a        = accum_ff;
      add_b        = mcand_ff;
      add_sub      = 1'b0;
      upd_sat      = sat32(add_out);
      div_y        = phase_ff ? (add_out >> SHIFT_POS) : (add_out >> SHIFT_SPRING);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) req_in = req_data;
         end
         ST_TARGET: tgt_in = tgt_calc;
         ST_DECIDE: begin
            left_in = dt_sel;
            cnt_in  = CNT_W'(dt_sel);
            fac_in  = 17'h10000;
            if (!zero_tick && tq >= drive_ff) drive_in = tq;
         end
         // release factor, one ms per multiply
         ST_DK_LOAD: begin
            mcand_in  = ACC_W'(fac_ff);
            mplier_in = MUL_W'(cfg_ff.release_per_ms);
            accum_in  = '0;
         end
         ST_DK_MUL, ST_DR_MUL, ST_SP_MK, ST_SP_MC, ST_SP_MH: begin
            add_sub = (state_ff == ST_SP_MC);
            if (!mul_done) begin
               if (mplier_ff[0]) accum_in = add_out;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end else begin
               if (state_ff == ST_DK_MUL) begin
                  fac_in = accum_ff[32:16];
                  cnt_in = cnt_ff - CNT_W'(1);
               end
               if (state_ff == ST_SP_MK) begin
                  mcand_in  = {{(ACC_W-32){vel_ff[31]}}, vel_ff};
                  mplier_in = MUL_W'(cfg_ff.spring_damping);
               end
               if (state_ff == ST_SP_MC) begin
                  mcand_in  = accum_ff;
                  accum_in  = '0;
                  mplier_in = MUL_W'(h_sel);
               end
            end
         end
         // drive relaxes towards the target
         ST_DR_LOAD: begin
            add_a     = ACC_W'(drive_ff);
            add_b     = ACC_W'(tq);
            add_sub   = 1'b1;
            mcand_in  = add_out;
            mplier_in = MUL_W'(fac_ff);
            accum_in  = '0;
         end
         ST_DR_ADD: begin
            add_a    = ACC_W'(tq);
            add_b    = ACC_W'(accum_ff[39:16]);
            drive_in = add_out[23:0];
         end
         // spring substep: error term
         ST_SP_ERR: begin
            add_a     = ACC_W'(drive_ff);
            add_b     = {{(ACC_W-32){pos_ff[31]}}, pos_ff};
            add_sub   = 1'b1;
            mcand_in  = add_out;
            mplier_in = MUL_W'(cfg_ff.spring_stiffness);
            accum_in  = '0;
            phase_in  = 1'b0;
         end
         // magnitude, power-of-two part of the divisor, first quotient guess
         ST_SP_ABS: begin
            add_a    = '0;
            add_b    = accum_ff;
            add_sub  = accum_ff[ACC_W-1];
            sign_in  = accum_ff[ACC_W-1];
            mcand_in = div_y;
            quo_in   = div_y >> 7;
            cnt_in   = CNT_W'(DIV_ITERS);
         end
         // divide by 125: q = (y + 3q) >> 7 climbs to floor(y/125) from below
         ST_DV_TRI: begin
            add_a    = quo_ff;
            add_b    = quo_ff << 1;
            accum_in = add_out;
         end
         ST_DV_SUM: begin
            add_a    = mcand_ff;
            add_b    = accum_ff;
            accum_in = add_out;
            if (cnt_ff != '0) begin
               quo_in = add_out >> 7;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         // remainder y - 125q, at most one step short
         ST_DV_REM: begin
            add_a   = accum_ff;
            add_b   = quo_ff << 7;
            add_sub = 1'b1;
            rem_in  = add_out[REM_W-1:0];
         end
         ST_DV_FIX: begin
            add_a  = quo_ff;
            add_b  = ACC_W'(rem_ff >= REM_W'(DIV_K));
            quo_in = add_out;
         end
         ST_SP_SGN: begin
            add_a    = '0;
            add_b    = quo_ff;
            add_sub  = sign_ff;
            accum_in = add_out;
         end
         // velocity first, then position from the new velocity
         ST_SP_UPD: begin
            add_a = phase_ff ? {{(ACC_W-32){pos_ff[31]}}, pos_ff}
                             : {{(ACC_W-32){vel_ff[31]}}, vel_ff};
            add_b = accum_ff;
            if (!phase_ff) begin
               vel_in    = upd_sat;
               mcand_in  = {{(ACC_W-32){upd_sat[31]}}, upd_sat};
               mplier_in = MUL_W'(h_sel);
               accum_in  = '0;
               phase_in  = 1'b1;
            end else begin
               pos_in  = upd_sat;
               left_in = left_ff - DT_W'(h_sel);
            end
         end
         // mechanical stops
         ST_STOPS: begin
            if (pos_ff[31]) begin
               pos_in = '0;
               if (vel_ff[31]) vel_in = '0;
            end else if (pos_ff > $signed({8'b0, full_q16})) begin
               pos_in = $signed({8'b0, full_q16});
               if (!vel_ff[31] && vel_ff != 0) vel_in = '0;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.needle_angle = needle;
               rsp_in.target_angle = tgt_ff;
               rsp_in.repaint      = paint;
               if (!zero_tick) begin
                  if (paint) begin
                     drawn_in = needle;
                     msd_in   = 16'd0;
                  end else begin
                     msd_in = msd_sat;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         drive_ff     <= '0;
         pos_ff       <= '0;
         vel_ff       <= '0;
         drawn_ff     <= '0;
         msd_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         drive_ff     <= drive_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         drawn_ff     <= drawn_in;
         msd_ff       <= msd_in;
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      tgt_ff    <= tgt_in;
      left_ff   <= left_in;
      cnt_ff    <= cnt_in;
      fac_ff    <= fac_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      accum_ff  <= accum_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      sign_ff   <= sign_in;
      phase_ff  <= phase_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dbm_at_s9        <= -9'sd73;
         cfg_ff.angle_at_s9      <= 16'd11520;
         cfg_ff.slope_below_s9   <= 16'd213;
         cfg_ff.slope_above_s9   <= 16'd192;
         cfg_ff.full_scale_angle <= 16'd23040;
         cfg_ff.release_per_ms   <= 16'd65405;
         cfg_ff.spring_stiffness <= 24'd40423;
         cfg_ff.spring_damping   <= 20'd4504;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DBM_AT_S9:        cfg_ff.dbm_at_s9        <= csr_data[8:0];
            CSR_ANGLE_AT_S9:      cfg_ff.angle_at_s9      <= csr_data[15:0];
            CSR_SLOPE_BELOW_S9:   cfg_ff.slope_below_s9   <= csr_data[15:0];
            CSR_SLOPE_ABOVE_S9:   cfg_ff.slope_above_s9   <= csr_data[15:0];
            CSR_FULL_SCALE_ANGLE: cfg_ff.full_scale_angle <= csr_data[15:0];
            CSR_RELEASE_PER_MS:   cfg_ff.release_per_ms   <= csr_data[15:0];
            CSR_SPRING_STIFFNESS: cfg_ff.spring_stiffness <= csr_data;
            CSR_SPRING_DAMPING:   cfg_ff.spring_damping   <= csr_data[19:0];
         endcase
      end
   end

endmodule

// ----- sv/mnb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnb_checker
// Port-level checks on the meter needle ballistics block, bound to the top.
// ----------------------------------------------------------------------------
module mnb_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input mnb_pkg::mnb_rsp_type rsp_data
);
   import mnb_pkg::*;

   // out of reset: idle, nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("not idle after reset");

   // a tick transfer keeps the block busy on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("ready right after tick transfer");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind meter_needle_ballistics mnb_checker u_mnb_checker (.*);
